// ----- rtl/sprite_animation_sequencer_unit_macros.svh -----
// Assertion macros for the sprite animation sequencer.
// Included by the top level; needs no other file.
`ifndef SPRITE_ANIMATION_SEQUENCER_UNIT_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sas: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sas: next-cycle check failed");

`endif

// ----- rtl/sas_pkg.sv -----
// Shared types and codes of the sprite animation sequencer.
// Used by every module of the block but sas_dur_mem; depends on nothing.
`timescale 1ns / 1ps

package sas_pkg;

  localparam int POS_W       = 40;
  localparam int DUR_W       = 16;
  localparam int CNT_W       = 5;
  localparam int FRAME_OUT_W = 4;
  localparam int ANIM_W      = 3;
  localparam int SPEED_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int DELTA_W     = 16;
  localparam int PROD_W      = DELTA_W + SPEED_W;

  localparam logic [SPEED_W-1:0] SPEED_ONE = 16'd256;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_MSG      = 2'd1,
    CMD_LOAD_DUR = 2'd2,
    CMD_LOAD_HDR = 2'd3
  } cmd_t;

  localparam logic [1:0] PS_PAUSED = 2'd0;
  localparam logic [1:0] PS_INC    = 2'd1;
  localparam logic [1:0] PS_DEC    = 2'd2;

  localparam logic [1:0] LOOP_NONE     = 2'd0;
  localparam logic [1:0] LOOP_REPEAT   = 2'd1;
  localparam logic [1:0] LOOP_PINGPONG = 2'd2;
  localparam logic [1:0] LOOP_HOLD     = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_PAUSE = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_START = 3'd3;
  localparam logic [2:0] ACT_CONT  = 3'd4;

  // Result word, frame index in the lowest bits.
  typedef struct packed {
    logic                   accepted;
    logic [ANIM_W-1:0]      anim_sel;
    logic [1:0]             play_state;
    logic [FRAME_OUT_W-1:0] frame_index;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [1:0]       mode;
    logic             anim_ok;
  } hdr_t;

  typedef struct packed {
    logic              en;
    logic [ANIM_W-1:0] anim;
    logic [CNT_W-1:0]  count;
    logic [1:0]        mode;
  } hdr_wr_t;

endpackage

// ----- rtl/sprite_animation_sequencer_unit.sv -----
// Sprite animation sequencer: plays one animated object from a table of frame
// durations, frame counts and loop modes (none, repeat, ping-pong, hold), driven by
// load, control-message and tick items on the input stream, one result word per
// item. Load and message items, and ticks while paused or on an empty animation,
// take one cycle. An active tick goes through ST_ADD, then ST_STEP, which makes
// one frame step per cycle (at most MAX_ADVANCE steps) through the single read
// port of the duration memory; no new item is taken meanwhile. Depends on sas_pkg,
// sas_dur_mem, sas_hdr_table, sas_core, sas_out_buf and the macros header.
`timescale 1ns / 1ps
`include "sprite_animation_sequencer_unit_macros.svh"

module sprite_animation_sequencer_unit #(
  parameter int MAX_FRAMES  = 16,
  parameter int NUM_ANIMS   = 8,
  parameter int MAX_ADVANCE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // delta_ms, msg_priority, msg_change_speed, msg_speed, anim_index, msg_action,
  // load_frame, load_duration, load_count, load_loop, zero pad
  input  logic [79:0] s_axis_tdata,
  // cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_index, play_state, selected animation, accepted, zero pad
  output logic [15:0] m_axis_tdata
);
  import sas_pkg::*;

  localparam int HN    = (NUM_ANIMS < (1 << ANIM_W)) ? NUM_ANIMS : (1 << ANIM_W);
  localparam int DEPTH = HN * MAX_FRAMES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  hdr_t              hdr;
  hdr_wr_t           hdr_wr;
  logic [ANIM_W-1:0] sel_anim;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [DUR_W-1:0]  mem_wr_data;
  logic [AW-1:0]     mem_rd_addr;
  logic [DUR_W-1:0]  mem_rd_data;
  logic              pend_full;
  logic              res_valid;
  res_t              res;
  res_t              out_word;

  sas_dur_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DUR_W)
  ) u_dur_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  sas_hdr_table #(
    .NUM_ANIMS  (NUM_ANIMS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_hdr_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (hdr_wr),
    .rd_anim (sel_anim),
    .hdr     (hdr)
  );

  sas_core #(
    .NUM_ANIMS   (NUM_ANIMS),
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_ADVANCE (MAX_ADVANCE),
    .AW          (AW)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .cmd              (s_axis_tuser),
    .delta_ms         (s_axis_tdata[15:0]),
    .msg_priority     (s_axis_tdata[23:16]),
    .msg_change_speed (s_axis_tdata[24]),
    .msg_speed        (s_axis_tdata[40:25]),
    .anim_index       (s_axis_tdata[43:41]),
    .msg_action       (s_axis_tdata[46:44]),
    .load_frame       (s_axis_tdata[50:47]),
    .load_duration    (s_axis_tdata[66:51]),
    .load_count       (s_axis_tdata[71:67]),
    .load_loop        (s_axis_tdata[73:72]),
    .hdr              (hdr),
    .hdr_wr           (hdr_wr),
    .sel_anim         (sel_anim),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data),
    .pend_full        (pend_full),
    .res_valid        (res_valid),
    .res              (res)
  );

  sas_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .pend_full (pend_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = {6'd0, out_word};

  // A load or message item lands in the output register or the pending slot at once.
  `SAS_ASSERT_NEXT(a_fast_item_result, clk, rst,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_TICK), m_axis_tvalid)
  `SAS_ASSERT_SAME(a_pend_behind_out, clk, rst, pend_full, m_axis_tvalid)
  `SAS_ASSERT_SAME(a_pend_blocks_input, clk, rst, pend_full, !s_axis_tready)

endmodule

// ----- rtl/sas_dur_mem.sv -----
// Frame duration memory: one write port, one registered read port.
// Standalone; no package needed.
`timescale 1ns / 1ps

module sas_dur_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/sas_hdr_table.sv -----
// Per-animation header table: frame count and loop mode, cleared by reset.
// Depends on sas_pkg.
`timescale 1ns / 1ps

module sas_hdr_table #(
  parameter int NUM_ANIMS  = 8,
  parameter int MAX_FRAMES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  sas_pkg::hdr_wr_t wr,
  input  logic [2:0]       rd_anim,
  output sas_pkg::hdr_t    hdr
);
  import sas_pkg::*;

  localparam int HN  = (NUM_ANIMS < (1 << ANIM_W)) ? NUM_ANIMS : (1 << ANIM_W);
  localparam int HIW = (HN > 1) ? $clog2(HN) : 1;

  logic [CNT_W-1:0] count_tab [HN];
  logic [1:0]       mode_tab  [HN];

  logic             wr_ok;
  logic             rd_ok;
  logic [HIW-1:0]   wr_idx;
  logic [HIW-1:0]   rd_idx;
  logic [CNT_W-1:0] wr_count;

  assign wr_ok  = 9'(wr.anim) < 9'(NUM_ANIMS);
  assign rd_ok  = 9'(rd_anim) < 9'(NUM_ANIMS);
  assign wr_idx = HIW'(wr.anim);
  assign rd_idx = HIW'(rd_anim);
  // Clamp counts above MAX_FRAMES.
  assign wr_count = (9'(wr.count) > 9'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : wr.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HN; i++) begin
        count_tab[i] <= '0;
        mode_tab[i]  <= LOOP_NONE;
      end
    end else if (wr.en && wr_ok) begin
      count_tab[wr_idx] <= wr_count;
      mode_tab[wr_idx]  <= wr.mode;
    end
  end

  assign hdr.count   = rd_ok ? count_tab[rd_idx] : '0;
  assign hdr.mode    = rd_ok ? mode_tab[rd_idx] : LOOP_NONE;
  assign hdr.anim_ok = rd_ok;

endmodule

// ----- rtl/sas_core.sv -----
// Playback state and sequencer: messages, loads and the per-tick frame-step loop
// over the duration memory. Depends on sas_pkg.
`timescale 1ns / 1ps

module sas_core #(
  parameter int NUM_ANIMS   = 8,
  parameter int MAX_FRAMES  = 16,
  parameter int MAX_ADVANCE = 64,
  parameter int AW          = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [sas_pkg::DELTA_W-1:0]   delta_ms,
  input  logic [sas_pkg::PRIO_W-1:0]    msg_priority,
  input  logic                          msg_change_speed,
  input  logic [sas_pkg::SPEED_W-1:0]   msg_speed,
  input  logic [sas_pkg::ANIM_W-1:0]    anim_index,
  input  logic [2:0]                    msg_action,
  input  logic [3:0]                    load_frame,
  input  logic [sas_pkg::DUR_W-1:0]     load_duration,
  input  logic [sas_pkg::CNT_W-1:0]     load_count,
  input  logic [1:0]                    load_loop,
  input  sas_pkg::hdr_t                 hdr,
  output sas_pkg::hdr_wr_t              hdr_wr,
  output logic [sas_pkg::ANIM_W-1:0]    sel_anim,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [sas_pkg::DUR_W-1:0]     mem_wr_data,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [sas_pkg::DUR_W-1:0]     mem_rd_data,
  input  logic                          pend_full,
  output logic                          res_valid,
  output sas_pkg::res_t                 res
);
  import sas_pkg::*;

  localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CMPW = (FW > CNT_W) ? FW : CNT_W;
  localparam int SCW  = $clog2(MAX_ADVANCE + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_STEP} state_t;

  state_t              state;
  logic [ANIM_W-1:0]   sel_q;
  logic [FW-1:0]       frame;
  logic [1:0]          run_state;
  logic [1:0]          before_pause;
  logic [PRIO_W-1:0]   held_prio;
  logic [SPEED_W-1:0]  speed;
  logic [POS_W-1:0]    position;
  logic [PROD_W-1:0]   product;
  logic [SCW-1:0]      step_cnt;

  logic                accept;
  logic                tick_live;
  logic                step_done;
  logic [POS_W:0]      pos_sum;
  logic [POS_W-1:0]    dur_pos;

  logic [CMPW-1:0]     last_c;
  logic [CMPW-1:0]     fr_c;
  logic [FW-1:0]       adv_frame;
  logic [1:0]          adv_state;

  logic                pass;
  logic [2:0]          act;
  logic [ANIM_W-1:0]   m_sel;
  logic [SPEED_W-1:0]  m_speed;
  logic [PRIO_W-1:0]   m_prio;
  logic [1:0]          m_run;
  logic [1:0]          m_bp;
  logic [FW-1:0]       m_frame;
  logic                m_clear;

  logic [AW-1:0]       base;
  logic [FW-1:0]       rd_frame;

  assign sel_anim  = sel_q;

  assign in_ready  = (state == ST_IDLE) && !pend_full;
  assign accept    = in_valid && in_ready;
  assign tick_live = (run_state != PS_PAUSED) && hdr.anim_ok && (hdr.count != '0);

  assign pos_sum   = {1'b0, position} + (POS_W + 1)'(product);
  assign dur_pos   = POS_W'({mem_rd_data, 8'h00});
  assign step_done = (step_cnt == SCW'(MAX_ADVANCE)) || (position <= dur_pos);

  // One frame step for the current direction and loop mode.
  always_comb begin
    last_c    = CMPW'(hdr.count) - CMPW'(1);
    fr_c      = CMPW'(frame);
    adv_frame = frame;
    adv_state = run_state;
    case (run_state)
      PS_INC: begin
        if (fr_c < last_c) begin
          adv_frame = frame + FW'(1);
        end else if (hdr.mode == LOOP_PINGPONG) begin
          if (frame != '0) adv_frame = frame - FW'(1);
          adv_state = PS_DEC;
        end else if (hdr.mode == LOOP_REPEAT) begin
          adv_frame = '0;
        end else if (hdr.mode == LOOP_NONE) begin
          adv_state = PS_PAUSED;
        end
      end
      PS_DEC: begin
        if (frame != '0) begin
          if (hdr.mode != LOOP_HOLD) adv_frame = frame - FW'(1);
        end else if (hdr.mode == LOOP_PINGPONG) begin
          if (hdr.count > CNT_W'(1)) adv_frame = FW'(1);
          adv_state = PS_INC;
        end else if (hdr.mode == LOOP_REPEAT) begin
          adv_frame = FW'(last_c);
        end else if (hdr.mode == LOOP_NONE) begin
          adv_state = PS_PAUSED;
        end
      end
      default: ;
    endcase
  end

  // Control message: priority check, then speed, animation switch and action.
  always_comb begin
    pass    = (msg_priority >= held_prio) || (run_state == PS_PAUSED);
    act     = msg_action;
    m_sel   = sel_q;
    m_speed = speed;
    m_prio  = held_prio;
    m_run   = run_state;
    m_bp    = before_pause;
    m_frame = frame;
    m_clear = 1'b0;
    if (anim_index != sel_q && act == ACT_CONT) act = ACT_START;
    if (pass) begin
      m_sel  = anim_index;
      m_prio = msg_priority;
      if (msg_change_speed) m_speed = msg_speed;
      case (act)
        ACT_PAUSE: begin
          if (run_state != PS_PAUSED) begin
            m_bp  = run_state;
            m_run = PS_PAUSED;
          end
        end
        ACT_STOP: begin
          m_bp    = PS_PAUSED;
          m_run   = PS_PAUSED;
          m_frame = '0;
          m_clear = 1'b1;
        end
        ACT_START: begin
          m_run   = PS_INC;
          m_frame = '0;
          m_clear = 1'b1;
        end
        ACT_CONT: begin
          if (run_state == PS_PAUSED) begin
            m_run = (before_pause == PS_PAUSED) ? PS_INC : before_pause;
            m_bp  = m_run;
          end
        end
        default: ;
      endcase
    end
  end

  // Duration read: current frame when the tick starts, the stepped frame after.
  assign base        = AW'(AW'(sel_q) * AW'(MAX_FRAMES));
  assign rd_frame    = (state == ST_STEP) ? adv_frame : frame;
  assign mem_rd_addr = base + AW'(rd_frame);

  assign mem_wr_en   = accept && (cmd == CMD_LOAD_DUR) && (9'(load_frame) < 9'(MAX_FRAMES))
                       && (9'(anim_index) < 9'(NUM_ANIMS));
  assign mem_wr_addr = AW'(AW'(anim_index) * AW'(MAX_FRAMES)) + AW'(load_frame);
  assign mem_wr_data = load_duration;

  assign hdr_wr.en    = accept && (cmd == CMD_LOAD_HDR);
  assign hdr_wr.anim  = anim_index;
  assign hdr_wr.count = load_count;
  assign hdr_wr.mode  = load_loop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sel_q        <= '0;
      frame        <= '0;
      run_state    <= PS_PAUSED;
      before_pause <= PS_PAUSED;
      held_prio    <= '0;
      speed        <= SPEED_ONE;
      position     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == CMD_TICK) begin
              if (tick_live) begin
                product <= PROD_W'(delta_ms) * PROD_W'(speed);
                state   <= ST_ADD;
              end
            end else if (cmd == CMD_MSG) begin
              sel_q        <= m_sel;
              speed        <= m_speed;
              held_prio    <= m_prio;
              run_state    <= m_run;
              before_pause <= m_bp;
              frame        <= m_frame;
              if (m_clear) position <= '0;
            end
          end
        end
        ST_ADD: begin
          // Saturate the advanced position.
          position <= pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
          step_cnt <= '0;
          state    <= ST_STEP;
        end
        ST_STEP: begin
          if (step_done) begin
            state <= ST_IDLE;
          end else begin
            position  <= position - dur_pos;
            frame     <= adv_frame;
            run_state <= adv_state;
            step_cnt  <= step_cnt + SCW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res_valid = (accept && !(cmd == CMD_TICK && tick_live)) ||
                (state == ST_STEP && step_done);
    res.frame_index = FRAME_OUT_W'(frame);
    res.play_state  = run_state;
    res.anim_sel    = sel_q;
    res.accepted    = 1'b0;
    if (state == ST_IDLE && cmd == CMD_MSG) begin
      res.frame_index = FRAME_OUT_W'(m_frame);
      res.play_state  = m_run;
      res.anim_sel    = m_sel;
      res.accepted    = pass;
    end
  end

endmodule

// ----- rtl/sas_out_buf.sv -----
// Output register with one pending slot, so a result can wait while the next
// item is taken. Depends on sas_pkg.
`timescale 1ns / 1ps

module sas_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  sas_pkg::res_t res,
  output logic          pend_full,
  output logic          out_valid,
  input  logic          out_ready,
  output sas_pkg::res_t out_word
);
  import sas_pkg::*;

  res_t pend;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_full <= 1'b0;
      out_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_full) begin
        // Pending word goes first; a new one takes its slot.
        out_word  <= pend;
        out_valid <= 1'b1;
        pend      <= res;
        pend_full <= res_valid;
      end else begin
        out_word  <= res;
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      pend      <= res;
      pend_full <= 1'b1;
    end
  end

endmodule

// ----- tb/sv/tb_sprite_animation_sequencer_unit.sv -----
// Self-checking testbench for sprite_animation_sequencer_unit: fills the frame tables,
// runs directed and random tick, message and load words, and checks every status word.
// Depends on sas_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb_sprite_animation_sequencer_unit;
  import sas_pkg::*;

  localparam int               MAX_ADVANCE = 64;
  localparam logic [4:0]       FRAME_SLOTS = 5'd16;
  localparam longint unsigned  POS_MAX     = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [2:0]       ACT_UNDEF   = 3'd7;
  localparam int               STIM_WORDS  = 1550;
  localparam int               CYCLE_LIMIT = 1000000;

  // Input word, same layout as s_axis_tdata, delta_ms in the lowest bits.
  typedef struct packed {
    logic [5:0]  pad;
    logic [1:0]  load_loop;
    logic [4:0]  load_count;
    logic [15:0] load_duration;
    logic [3:0]  load_frame;
    logic [2:0]  msg_action;
    logic [2:0]  anim_index;
    logic [15:0] msg_speed;
    logic        msg_change_speed;
    logic [7:0]  msg_priority;
    logic [15:0] delta_ms;
  } anim_word_t;

  typedef struct {
    cmd_t       cmd;
    anim_word_t f;
  } anim_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  sprite_animation_sequencer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  anim_item_t input_words[$];
  res_t       expected_status[$];
  anim_item_t next_item;
  res_t       want_res;
  res_t       got_res;

  // Sequencer state mirrored for prediction.
  logic [15:0]     dur_mem [0:127];
  logic [4:0]      cnt_mem [0:7];
  logic [1:0]      loop_mem [0:7];
  logic [2:0]      sel_anim;
  logic [3:0]      cur_frame;
  logic [1:0]      run_st;
  logic [1:0]      paused_from;
  logic [7:0]      prio_held;
  logic [15:0]     speed_now;
  longint unsigned pos;

  int gen_cnt = 0;
  int sent_cnt = 0;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int tick_cnt = 0;
  int msg_cnt = 0;
  int acc_cnt = 0;
  int load_cnt = 0;
  int checked_cnt = 0;
  int sat_cnt = 0;
  int cap_cnt = 0;
  int tx_idle_pct;
  int rx_stall_pct;
  int gen_anim = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Rotate through sender idle and receiver stall phases every 150 words sent.
  always_comb begin
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    case ((sent_cnt / 150) % 4)
      1: tx_idle_pct = 75;
      2: rx_stall_pct = 75;
      3: begin
        tx_idle_pct  = 19;
        rx_stall_pct = 19;
      end
      default: ;
    endcase
  end

  task automatic advance_sequencer(input cmd_t cmd, input anim_word_t w, output res_t r);
    logic [2:0]      act;
    logic [4:0]      cnt;
    logic [4:0]      top_frame;
    logic [1:0]      mode;
    longint unsigned dur;
    logic            took;
    took = 1'b0;
    case (cmd)
      CMD_TICK: begin
        tick_cnt++;
        cnt = cnt_mem[sel_anim];
        if (run_st != PS_PAUSED && cnt != 0) begin
          mode      = loop_mem[sel_anim];
          top_frame = cnt - 5'd1;
          pos       = pos + 64'(w.delta_ms) * 64'(speed_now);
          if (pos > POS_MAX) begin
            pos = POS_MAX;
            sat_cnt++;
          end
          for (int n = 0; n < MAX_ADVANCE; n++) begin
            dur = {40'd0, dur_mem[{sel_anim, cur_frame}], 8'd0};
            if (pos <= dur) break;
            if (n == MAX_ADVANCE - 1) cap_cnt++;
            pos = pos - dur;
            // Once paused mid tick, remaining steps only drain the position.
            if (run_st == PS_INC) begin
              if ({1'b0, cur_frame} < top_frame) cur_frame = cur_frame + 4'd1;
              else if (mode == LOOP_PINGPONG) begin
                if (cur_frame != 0) cur_frame = cur_frame - 4'd1;
                run_st = PS_DEC;
              end else if (mode == LOOP_REPEAT) cur_frame = '0;
              else if (mode == LOOP_NONE) run_st = PS_PAUSED;
            end else if (run_st == PS_DEC) begin
              if (cur_frame != 0) begin
                if (mode != LOOP_HOLD) cur_frame = cur_frame - 4'd1;
              end else if (mode == LOOP_PINGPONG) begin
                if (cnt > 5'd1) cur_frame = 4'd1;
                run_st = PS_INC;
              end else if (mode == LOOP_REPEAT) cur_frame = top_frame[3:0];
              else if (mode == LOOP_NONE) run_st = PS_PAUSED;
            end
          end
        end
      end
      CMD_MSG: begin
        msg_cnt++;
        if (w.msg_priority >= prio_held || run_st == PS_PAUSED) begin
          took = 1'b1;
          acc_cnt++;
          if (w.msg_change_speed) speed_now = w.msg_speed;
          act = w.msg_action;
          if (w.anim_index != sel_anim) begin
            sel_anim = w.anim_index;
            if (act == ACT_CONT) act = ACT_START;
          end
          prio_held = w.msg_priority;
          case (act)
            ACT_PAUSE: begin
              if (run_st != PS_PAUSED) begin
                paused_from = run_st;
                run_st      = PS_PAUSED;
              end
            end
            ACT_STOP: begin
              paused_from = PS_PAUSED;
              run_st      = PS_PAUSED;
              cur_frame   = '0;
              pos         = 0;
            end
            ACT_START: begin
              run_st    = PS_INC;
              cur_frame = '0;
              pos       = 0;
            end
            ACT_CONT: begin
              if (run_st == PS_PAUSED) begin
                if (paused_from == PS_PAUSED) paused_from = PS_INC;
                run_st = paused_from;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_LOAD_DUR: begin
        load_cnt++;
        dur_mem[{w.anim_index, w.load_frame}] = w.load_duration;
      end
      default: begin
        load_cnt++;
        cnt_mem[w.anim_index]  = (w.load_count > FRAME_SLOTS) ? FRAME_SLOTS : w.load_count;
        loop_mem[w.anim_index] = w.load_loop;
      end
    endcase
    r = '{accepted: took, anim_sel: sel_anim, play_state: run_st,
          frame_index: cur_frame};
  endtask

  task automatic check_field(input string fld, input logic [7:0] want, input logic [7:0] seen);
    if (want !== seen) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fld, want, seen);
    end
  endtask

  // Sender: hold the word until taken, then pick the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (input_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_item = input_words.pop_front();
        s_axis_tdata  <= next_item.f;
        s_axis_tuser  <= next_item.cmd;
        s_axis_tvalid <= 1'b1;
        sent_cnt      <= sent_cnt + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: predict on every accepted input word, then check the result word.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      foreach (cnt_mem[i]) begin
        cnt_mem[i]  = '0;
        loop_mem[i] = '0;
      end
      sel_anim    = '0;
      cur_frame   = '0;
      run_st      = PS_PAUSED;
      paused_from = PS_PAUSED;
      prio_held   = '0;
      speed_now   = SPEED_ONE;
      pos         = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_sequencer(cmd_t'(s_axis_tuser), anim_word_t'(s_axis_tdata), want_res);
        expected_status.push_back(want_res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = res_t'(m_axis_tdata[9:0]);
        if (expected_status.size() == 0) begin
          err_cnt++;
          $display("%0t ns: unexpected result word, expected none, got %h", $time,
                   m_axis_tdata);
        end else begin
          want_res = expected_status.pop_front();
          checked_cnt++;
          check_field("frame_index", want_res.frame_index, got_res.frame_index);
          check_field("play_state", want_res.play_state, got_res.play_state);
          check_field("anim_sel", want_res.anim_sel, got_res.anim_sel);
          check_field("accepted", want_res.accepted, got_res.accepted);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_status.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic anim_word_t rand_word();
    logic [95:0] raw;
    anim_word_t  w;
    raw   = {$urandom, $urandom, $urandom};
    w     = raw[79:0];
    w.pad = '0;
    return w;
  endfunction

  task automatic push_word(input cmd_t c, input anim_word_t w);
    input_words.push_back('{cmd: c, f: w});
    gen_cnt++;
  endtask

  task automatic push_tick(input logic [15:0] delta);
    anim_word_t w;
    w = rand_word();
    w.delta_ms = delta;
    push_word(CMD_TICK, w);
  endtask

  task automatic push_msg(input logic [7:0] prio, input logic chg, input logic [15:0] spd,
                          input logic [2:0] anim, input logic [2:0] act);
    anim_word_t w;
    w = rand_word();
    w.msg_priority     = prio;
    w.msg_change_speed = chg;
    w.msg_speed        = spd;
    w.anim_index       = anim;
    w.msg_action       = act;
    push_word(CMD_MSG, w);
  endtask

  task automatic push_dur(input logic [2:0] anim, input logic [3:0] frame,
                          input logic [15:0] dur);
    anim_word_t w;
    w = rand_word();
    w.anim_index    = anim;
    w.load_frame    = frame;
    w.load_duration = dur;
    push_word(CMD_LOAD_DUR, w);
  endtask

  task automatic push_hdr(input logic [2:0] anim, input logic [4:0] count,
                          input logic [1:0] mode);
    anim_word_t w;
    w = rand_word();
    w.anim_index = anim;
    w.load_count = count;
    w.load_loop  = mode;
    push_word(CMD_LOAD_HDR, w);
  endtask

  // Mostly short frames so that ticks step a few frames.
  function automatic logic [15:0] pick_duration();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return 16'd0;
    if (k < 13) return 16'hFFFF;
    if (k < 20) return 16'($urandom);
    return 16'($urandom_range(1, 40));
  endfunction

  function automatic logic [15:0] pick_speed();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 16'($urandom_range(64, 1024));
    if (k < 8) return 16'($urandom_range(0, 255));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_delta();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return 16'($urandom_range(0, 150));
    if (k < 85) return 16'($urandom_range(0, 2000));
    if (k < 95) return 16'($urandom);
    return (k % 2) ? 16'hFFFF : 16'd0;
  endfunction

  task automatic build_stimulus();
    int         r;
    int         k;
    int         a;
    logic [2:0] act;
    logic [4:0] count;
    logic [1:0] mode;
    bit         sat_done;
    sat_done = 0;
    // Write every duration slot first so no tick reads an unwritten one.
    for (int i = 0; i < 128; i++) push_dur(3'(i / 16), 4'(i % 16), pick_duration());

    push_tick(16'd40);                              // paused after reset
    push_hdr(3'd0, 5'd4, LOOP_NONE);
    push_msg(8'd0, 1'b0, 16'd0, 3'd0, ACT_START);
    push_tick(16'd0);
    push_dur(3'd0, 4'd0, 16'h0000);
    push_tick(16'hFFFF);                            // run off the end, pause mid tick
    push_hdr(3'd1, 5'd31, LOOP_PINGPONG);           // count clamps to sixteen
    push_dur(3'd1, 4'd1, 16'hFFFF);
    push_msg(8'hFF, 1'b1, 16'hFFFF, 3'd1, ACT_CONT); // switch turns continue into start
    push_tick(16'hFFFF);                            // step cap
    push_msg(8'd10, 1'b1, 16'd0, 3'd1, ACT_PAUSE);  // low priority while playing
    push_msg(8'hFF, 1'b0, 16'd0, 3'd1, ACT_PAUSE);
    push_msg(8'd0, 1'b1, SPEED_ONE, 3'd1, ACT_CONT);
    push_hdr(3'd2, 5'd1, LOOP_PINGPONG);            // single frame ping-pong
    push_msg(8'd0, 1'b0, 16'd0, 3'd2, ACT_START);
    push_tick(16'd2000);
    push_hdr(3'd3, 5'd3, LOOP_HOLD);
    push_msg(8'd0, 1'b0, 16'd0, 3'd3, ACT_START);
    push_tick(16'd500);
    push_hdr(3'd4, 5'd0, LOOP_REPEAT);              // empty animation
    push_msg(8'd0, 1'b0, 16'd0, 3'd4, ACT_START);
    push_tick(16'd100);
    push_msg(8'd0, 1'b0, 16'd0, 3'd4, ACT_UNDEF);
    push_msg(8'd0, 1'b0, 16'd0, 3'd4, ACT_STOP);
    push_hdr(3'd5, 5'd16, LOOP_REPEAT);
    push_msg(8'd0, 1'b0, 16'd0, 3'd5, ACT_START);
    push_tick(16'd300);
    push_hdr(3'd5, 5'd2, LOOP_REPEAT);              // frame now beyond the count
    push_tick(16'd300);
    push_hdr(3'd6, 5'd4, LOOP_PINGPONG);
    push_msg(8'd0, 1'b0, 16'd0, 3'd6, ACT_NONE);    // switch keeps the frame
    push_tick(16'd200);

    while (gen_cnt < STIM_WORDS) begin
      if (!sat_done && gen_cnt > 700) begin
        // Zero durations never drain, so max ticks drive the position to saturation.
        sat_done = 1;
        push_hdr(3'd7, 5'd16, LOOP_REPEAT);
        for (int f = 0; f < 16; f++) push_dur(3'd7, 4'(f), 16'd0);
        push_msg(8'hFF, 1'b1, 16'hFFFF, 3'd7, ACT_START);
        repeat (270) push_tick(16'hFFFF);
        for (int f = 0; f < 16; f++) push_dur(3'd7, 4'(f), 16'hFFFF);
        repeat (12) push_tick(16'($urandom_range(0, 50)));
        for (int f = 0; f < 16; f++) push_dur(3'd7, 4'(f), pick_duration());
        gen_anim = 7;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        push_word(cmd_t'($urandom_range(0, 3)), rand_word());
      end else if (r < 13) begin
        a = $urandom_range(0, 7);
        k = $urandom_range(0, 19);
        if (k == 0) count = 5'd0;
        else if (k < 3) count = 5'd1;
        else if (k == 3) count = 5'($urandom_range(17, 31));
        else count = 5'($urandom_range(2, 16));
        k = $urandom_range(0, 9);
        if (k < 3) mode = LOOP_NONE;
        else if (k < 6) mode = LOOP_REPEAT;
        else if (k < 9) mode = LOOP_PINGPONG;
        else mode = LOOP_HOLD;
        push_hdr(3'(a), count, mode);
        repeat ($urandom_range(0, 3))
          push_dur(3'(a), 4'($urandom_range(0, 15)), pick_duration());
        push_msg(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_speed(),
                 3'(a), ACT_START);
        gen_anim = a;
      end else if (r < 33) begin
        a = ($urandom_range(0, 9) < 6) ? gen_anim : $urandom_range(0, 7);
        k = $urandom_range(0, 9);
        if (k < 2) act = ACT_PAUSE;
        else if (k < 5) act = ACT_CONT;
        else if (k == 5) act = ACT_STOP;
        else if (k < 8) act = ACT_START;
        else if (k == 8) act = ACT_NONE;
        else act = 3'($urandom_range(ACT_NONE, ACT_UNDEF));
        push_msg(8'($urandom_range(0, 255)), ($urandom_range(0, 9) < 3), pick_speed(),
                 3'(a), act);
        gen_anim = a;
      end else if (r < 41) begin
        push_dur(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), pick_duration());
      end else begin
        push_tick(pick_delta());
      end
    end
  endtask

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (input_words.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    // Leave room for the longest tick and a stray word.
    repeat (100) @(posedge clk);
    $display("Checked %0d status words: %0d ticks, %0d messages (%0d taken), %0d loads",
             checked_cnt, tick_cnt, msg_cnt, acc_cnt, load_cnt);
    $display("Position saturated on %0d ticks, step cap hit on %0d ticks, %0d errors",
             sat_cnt, cap_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
